// ----- design/fsha_pkg.sv -----
// Shared types and constants for the fit-strategy hole allocator.
`timescale 1ns / 1ps

package fsha_pkg;

    localparam int HOLE_SLOTS = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int SIZE_W     = 16;
    localparam int SUM_W      = 20;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic REG_FIT_MODE     = 1'b0;
    localparam logic REG_HOLES_IN_USE = 1'b1;

    localparam logic [CNT_W-1:0] HOLES_RESET = CNT_W'(HOLE_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // Verdict of the shared compare unit on one hole
    typedef struct packed {
        logic fits;
        logic take;
    } fit_status_t;

endpackage

// ----- design/fsha_hole_table.sv -----
// Hole size table: one write port, one read port, cleared by reset.
`timescale 1ns / 1ps

module fsha_hole_table
    import fsha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [SIZE_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [SIZE_W-1:0] rd_data
);

    logic [SIZE_W-1:0] hole_reg [HOLE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLE_SLOTS; i++)
            begin
                hole_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            hole_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = hole_reg[rd_addr];

endmodule

// ----- design/fsha_fit_unit.sv -----
// Shared subtract and compare unit used for every scan step and the final update.
`timescale 1ns / 1ps

module fsha_fit_unit
    import fsha_pkg::*;
(
    input  logic [1:0]        fit_mode,
    input  logic [SIZE_W-1:0] hole,
    input  logic [SIZE_W-1:0] amount,
    input  logic              found,
    input  logic [SIZE_W-1:0] metric,
    output logic [SIZE_W-1:0] diff,
    output fit_status_t       status
);

    logic [SIZE_W:0] wide_diff;
    logic            better;

    assign wide_diff = {1'b0, hole} - {1'b0, amount};
    assign diff      = wide_diff[SIZE_W-1:0];

    always_comb
    begin
        case (fit_mode)
            MODE_BEST:  better = diff < metric;
            MODE_WORST: better = hole > metric;
            default:    better = 1'b1;
        endcase
        status.fits = ~wide_diff[SIZE_W];
        status.take = status.fits && (!found || better);
    end

endmodule

// ----- design/fit_strategy_hole_allocator_core.sv -----
// Top level of the fit-strategy hole allocator: sequencer, registers and ports.
`timescale 1ns / 1ps

// Fit-strategy hole allocator.
// Input words arrive on the s_ stream: tuser carries the opcode (load or request),
// tdata the hole index and amount. A load overwrites one hole's size; a request
// scans holes 0 .. min(holes_in_use, 16)-1 for a fit (first, best or worst fit, ties to the
// lower index) and subtracts the request from the chosen hole.
// Every input word yields exactly one result word on the m_ stream.
// Sequence: a load goes from acceptance straight to its update step.
// A request first scans N = min(holes_in_use, 16) holes, one per
// cycle through the shared subtract/compare unit; first fit stops at the first
// hit. The single table read port and the one shared unit set this pace;
// one word is in work at a time.
// The result sits in an output register: the next input word is accepted while
// a result still waits, and the block holds in its update step only if the
// receiver has not taken the previous result.
// Reset clears all hole sizes and the free total, sets first fit and 16 holes.
// Configuration (APB) must be written only while the block is idle; the block itself does not enforce this.

module fit_strategy_hole_allocator_core
    import fsha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hole_index[3:0], amount[19:4], zero pad
    input  logic        s_tuser,   // opcode[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // granted[0], hole_number[4:1], size_before[20:5],
                                   // size_after[36:21], free_total[56:37], zero pad
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    // accepted word
    logic              op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SIZE_W-1:0] amt_reg, amt_next;

    // scan bookkeeping
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [SIZE_W-1:0] metric_reg, metric_next;

    // configuration and running total
    logic [1:0]        fit_mode_reg;
    logic [CNT_W-1:0]  holes_reg;
    logic [SUM_W-1:0]  free_sum_reg, free_sum_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_granted_reg, out_granted_next;
    logic [IDX_W-1:0]  out_num_reg, out_num_next;
    logic [SIZE_W-1:0] out_before_reg, out_before_next;
    logic [SIZE_W-1:0] out_after_reg, out_after_next;
    logic [SUM_W-1:0]  out_total_reg, out_total_next;

    // table and shared unit
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    logic [SIZE_W-1:0] tbl_wr_data;
    logic [IDX_W-1:0]  tbl_rd_addr;
    logic [SIZE_W-1:0] tbl_rd_data;
    logic [SIZE_W-1:0] unit_diff;
    fit_status_t       unit_status;

    logic              in_accept;
    logic              out_free;
    logic              cfg_write;
    logic [CNT_W-1:0]  limit;
    logic              scan_last;
    logic              first_fit;
    logic              update_fire;
    logic              grant_now;

    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign limit       = (holes_reg > CNT_W'(HOLE_SLOTS)) ? CNT_W'(HOLE_SLOTS) : holes_reg;
    assign scan_last   = scan_cnt_reg == (limit - CNT_W'(1));
    assign first_fit   = (fit_mode_reg != MODE_BEST) && (fit_mode_reg != MODE_WORST);
    assign update_fire = (state_reg == ST_UPDATE) && out_free;
    assign grant_now   = (op_reg == OP_LOAD) || found_reg;

    fsha_hole_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    fsha_fit_unit u_fit (
        .fit_mode (fit_mode_reg),
        .hole     (tbl_rd_data),
        .amount   (amt_reg),
        .found    (found_reg),
        .metric   (metric_reg),
        .diff     (unit_diff),
        .status   (unit_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == OP_LOAD || limit == '0)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last || (unit_status.take && first_fit))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs: handshake and table port steering
    always_comb
    begin
        s_tready    = 1'b0;
        tbl_rd_addr = pick_reg;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = idx_reg;
        tbl_wr_data = amt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                tbl_rd_addr = scan_cnt_reg[IDX_W-1:0];
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_LOAD)
                begin
                    tbl_rd_addr = idx_reg;
                    tbl_wr_en   = out_free;
                end
                else
                begin
                    tbl_wr_en   = out_free && found_reg;
                    tbl_wr_addr = pick_reg;
                    tbl_wr_data = unit_diff;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next          = op_reg;
        idx_next         = idx_reg;
        amt_next         = amt_reg;
        scan_cnt_next    = scan_cnt_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        metric_next      = metric_reg;
        free_sum_next    = free_sum_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_granted_next = out_granted_reg;
        out_num_next     = out_num_reg;
        out_before_next  = out_before_reg;
        out_after_next   = out_after_reg;
        out_total_next   = out_total_reg;

        // capture the word and reset the scan
        if (in_accept)
        begin
            op_next       = s_tuser;
            idx_next      = s_tdata[3:0];
            amt_next      = s_tdata[19:4];
            scan_cnt_next = '0;
            found_next    = 1'b0;
            pick_next     = '0;
            metric_next   = '0;
        end

        // one hole per cycle through the shared unit
        if (state_reg == ST_SCAN)
        begin
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            if (unit_status.take)
            begin
                found_next  = 1'b1;
                pick_next   = scan_cnt_reg[IDX_W-1:0];
                metric_next = (fit_mode_reg == MODE_WORST) ? tbl_rd_data : unit_diff;
            end
        end

        // commit the table change and load the result register
        if (update_fire)
        begin
            out_valid_next   = 1'b1;
            out_granted_next = grant_now;
            if (op_reg == OP_LOAD)
            begin
                free_sum_next   = free_sum_reg - SUM_W'(tbl_rd_data) + SUM_W'(amt_reg);
                out_num_next    = idx_reg;
                out_before_next = tbl_rd_data;
                out_after_next  = amt_reg;
            end
            else if (found_reg)
            begin
                free_sum_next   = free_sum_reg - SUM_W'(amt_reg);
                out_num_next    = pick_reg;
                out_before_next = tbl_rd_data;
                out_after_next  = unit_diff;
            end
            else
            begin
                out_num_next    = '0;
                out_before_next = '0;
                out_after_next  = '0;
            end
            out_total_next = free_sum_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            free_sum_reg  <= '0;
            fit_mode_reg  <= MODE_FIRST;
            holes_reg     <= HOLES_RESET;
            scan_cnt_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            free_sum_reg  <= free_sum_next;
            scan_cnt_reg  <= scan_cnt_next;
            found_reg     <= found_next;
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_FIT_MODE:     fit_mode_reg <= pwdata[1:0];
                    REG_HOLES_IN_USE: holes_reg    <= pwdata[CNT_W-1:0];
                    default:          fit_mode_reg <= fit_mode_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        amt_reg         <= amt_next;
        pick_reg        <= pick_next;
        metric_reg      <= metric_next;
        out_granted_reg <= out_granted_next;
        out_num_reg     <= out_num_next;
        out_before_reg  <= out_before_next;
        out_after_reg   <= out_after_next;
        out_total_reg   <= out_total_next;
    end

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_FIT_MODE:     prdata = {30'd0, fit_mode_reg};
            REG_HOLES_IN_USE: prdata = {{(32-CNT_W){1'b0}}, holes_reg};
            default:          prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_after_reg, out_before_reg,
                       out_num_reg, out_granted_reg};

endmodule

// ----- bench/tb_fit_strategy_hole_allocator_core.sv -----
// Self-checking testbench for the fit-strategy hole allocator core.
`timescale 1ns / 1ps

// Drives load and request words into the allocator under random stalls on both
// streams, mirrors the hole table in a scoreboard class and compares every
// result word field by field. Fit mode and scan count are reprogrammed over APB
// between phases, only after every outstanding result has come back.

module tb_fit_strategy_hole_allocator_core;
    import fsha_pkg::*;

    localparam int         STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int         PHASE_WORDS  = 85;
    localparam int         PHASES       = 8;
    localparam logic [1:0] MODE_SPARE   = 2'd3;   // unused code, acts as first fit
    localparam int         REPORT_LIMIT = 10;

    // One result word, unpacked
    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  hole;
        logic [SIZE_W-1:0] size_before;
        logic [SIZE_W-1:0] size_after;
        logic [SUM_W-1:0]  free_total;
    } alloc_outcome_t;

    // Mirror of the hole table; predicts the outcome of each accepted word
    // and keeps the outcomes still owed by the block.
    class allocation_ledger;
        logic [SIZE_W-1:0] hole_sizes[HOLE_SLOTS];
        logic [SUM_W-1:0]  free_sum;
        logic [1:0]        fit_mode;
        logic [CNT_W-1:0]  scan_count;
        alloc_outcome_t    owed_outcomes[$];
        int errors, n_loads, n_requests, n_refused, n_zero_requests, n_writes;

        function new();
            foreach (hole_sizes[i]) hole_sizes[i] = '0;
            free_sum   = '0;
            fit_mode   = MODE_FIRST;
            scan_count = HOLES_RESET;
        endfunction

        function int pending();
            return owed_outcomes.size();
        endfunction

        function void write_register(logic sel, logic [31:0] value);
            n_writes++;
            if (sel == REG_FIT_MODE)
                fit_mode = value[1:0];
            else
                scan_count = value[CNT_W-1:0];
        endfunction

        function void note_word(logic op, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] amt);
            alloc_outcome_t r;
            int             lim;
            int             i;
            int             pick;
            bit             found;
            bit             stop;
            logic [SIZE_W-1:0] metric;
            r      = '0;
            found  = 0;
            stop   = 0;
            pick   = 0;
            metric = '0;
            if (op == OP_LOAD) begin
                n_loads++;
                r.granted     = 1'b1;
                r.hole        = idx;
                r.size_before = hole_sizes[idx];
                r.size_after  = amt;
                free_sum      = free_sum - SUM_W'(hole_sizes[idx]) + SUM_W'(amt);
                hole_sizes[idx] = amt;
            end
            else begin
                n_requests++;
                if (amt == '0)
                    n_zero_requests++;
                lim = (scan_count < HOLE_SLOTS) ? int'(scan_count) : HOLE_SLOTS;
                for (i = 0; i < lim && !stop; i++) begin
                    if (hole_sizes[i] >= amt) begin
                        case (fit_mode)
                            MODE_BEST:
                                if (!found || (hole_sizes[i] - amt) < metric) begin
                                    found  = 1;
                                    pick   = i;
                                    metric = hole_sizes[i] - amt;
                                end
                            MODE_WORST:
                                if (!found || hole_sizes[i] > metric) begin
                                    found  = 1;
                                    pick   = i;
                                    metric = hole_sizes[i];
                                end
                            default:
                            begin
                                found = 1;
                                pick  = i;
                                stop  = 1;
                            end
                        endcase
                    end
                end
                if (found) begin
                    r.granted         = 1'b1;
                    r.hole            = IDX_W'(pick);
                    r.size_before     = hole_sizes[pick];
                    r.size_after      = hole_sizes[pick] - amt;
                    hole_sizes[pick]  = r.size_after;
                    free_sum          = free_sum - SUM_W'(amt);
                end
                else
                    n_refused++;
            end
            r.free_total = free_sum;
            owed_outcomes.push_back(r);
        endfunction

        function void check_word(logic [63:0] word);
            alloc_outcome_t got;
            alloc_outcome_t want;
            got.granted     = word[0];
            got.hole        = word[4:1];
            got.size_before = word[20:5];
            got.size_after  = word[36:21];
            got.free_total  = word[56:37];
            if (owed_outcomes.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result word %h with nothing outstanding", word);
                return;
            end
            want = owed_outcomes.pop_front();
            if (got.granted !== want.granted || got.hole !== want.hole
                || got.size_before !== want.size_before
                || got.size_after !== want.size_after
                || got.free_total !== want.free_total) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch: expected granted=%0d hole=%0d before=%0d after=%0d free=%0d",
                             want.granted, want.hole, want.size_before, want.size_after,
                             want.free_total);
                    $display("          actual   granted=%0d hole=%0d before=%0d after=%0d free=%0d",
                             got.granted, got.hole, got.size_before, got.size_after,
                             got.free_total);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // hole_index[3:0], amount[19:4], zero pad
    logic        s_tuser;    // opcode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // granted[0], hole_number[4:1], size_before[20:5],
                             // size_after[36:21], free_total[56:37], zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    allocation_ledger ledger = new();
    bit               steady;          // no idling on either side while set
    int               stall_cycles;

    // Register plan of the random phases: every mode including the spare code,
    // scan counts at both ends and beyond the table.
    logic [1:0]       mode_plan[PHASES] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE,
                                            MODE_BEST, MODE_WORST, MODE_FIRST, MODE_BEST};
    logic [CNT_W-1:0] scan_plan[PHASES] = '{5'd16, 5'd1, 5'd16, 5'd5,
                                            5'd31, 5'd17, 5'd16, 5'd16};

    fit_strategy_hole_allocator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: drop tready at random with a 28 percent chance unless in a steady stretch
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 28);
    end

    // Sample every handshake at the rising edge, before the block's own updates land.
    // Inputs are noted before results are checked so that a word accepted at the
    // same edge as a result never races its own expectation.
    always @(posedge clk)
    begin : observe
        bit moved;
        moved = 0;
        if (rst_n) begin
            if (psel && penable && pwrite && pready) begin
                ledger.write_register(paddr[2], pwdata);
                moved = 1;
            end
            if (s_tvalid && s_tready) begin
                ledger.note_word(s_tuser, s_tdata[3:0], s_tdata[19:4]);
                moved = 1;
            end
            if (m_tvalid && m_tready) begin
                ledger.check_word(m_tdata);
                moved = 1;
            end
            // Watchdog: a run that stops moving is a failure
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, ledger.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one word; hold it until the block takes it. Called and left at a
    // falling edge, with tvalid still high so a following word can keep it high.
    task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] amt);
        while (!steady && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, amt, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop the input stream and wait until every owed result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
    endtask

    // APB write with setup and access phases; the ledger picks it up from the bus itself
    task automatic apb_write(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_policy(logic [1:0] mode, logic [CNT_W-1:0] count);
        settle();
        apb_write(REG_FIT_MODE, 32'(mode));
        apb_write(REG_HOLES_IN_USE, 32'(count));
    endtask

    // Hole sizes: mostly small so requests hit often, some full range
    function automatic logic [SIZE_W-1:0] load_amount();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return SIZE_W'($urandom);
        else if (roll < 6)
            return SIZE_W'($urandom_range(2000));
        else
            return SIZE_W'($urandom_range(20000));
    endfunction

    initial
    begin
        int               p;
        int               i;
        int               roll;
        int               lim;
        int               j;
        logic [SIZE_W-1:0] amt;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 0;
        stall_cycles = 0;
        scan_plan[PHASES-1] = CNT_W'($urandom_range(1, HOLE_SLOTS));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset policy is first fit over all sixteen holes.
        send_word(OP_REQUEST, 4'd0, 16'd0);        // zero request on an empty table
        send_word(OP_REQUEST, 4'd0, 16'd1);        // nothing fits
        send_word(OP_LOAD, 4'd0, 16'hFFFF);
        send_word(OP_LOAD, 4'd15, 16'hFFFF);
        send_word(OP_LOAD, 4'd3, 16'd50);
        send_word(OP_LOAD, 4'd7, 16'd100);
        send_word(OP_LOAD, 4'd9, 16'd48);
        send_word(OP_REQUEST, 4'd0, 16'hFFFF);     // empties hole 0 exactly
        send_word(OP_REQUEST, 4'd0, 16'd40);       // lowest fitting index

        // Best fit: tightest hole, then a tie on zero leftover
        set_policy(MODE_BEST, HOLES_RESET);
        send_word(OP_REQUEST, 4'd0, 16'd45);
        send_word(OP_LOAD, 4'd4, 16'd100);
        send_word(OP_REQUEST, 4'd0, 16'd100);

        // Worst fit: two equal largest holes, lower index must win
        set_policy(MODE_WORST, HOLES_RESET);
        send_word(OP_LOAD, 4'd12, 16'hFFFF);
        send_word(OP_REQUEST, 4'd0, 16'd1);

        // Spare mode code behaves as first fit; scan only hole 0
        set_policy(MODE_SPARE, 5'd1);
        send_word(OP_REQUEST, 4'd0, 16'd0);
        send_word(OP_REQUEST, 4'd0, 16'd1);

        // Scan count zero refuses even a zero request; loads still land
        set_policy(MODE_BEST, 5'd0);
        send_word(OP_REQUEST, 4'd0, 16'd0);
        send_word(OP_LOAD, 4'd15, 16'd0);

        // Scan count past the table end covers all slots
        set_policy(MODE_WORST, 5'd31);
        send_word(OP_REQUEST, 4'd0, 16'd2);
        send_word(OP_LOAD, 4'd1, 16'hAAAA);
        send_word(OP_LOAD, 4'd2, 16'h5555);
        send_word(OP_REQUEST, 4'd0, 16'h5555);

        // Random phases: loads and fitting requests, with some raw noise words.
        // Request sizes are drawn against the mirrored table so most of them land.
        for (p = 0; p < PHASES; p++) begin
            set_policy(mode_plan[p], scan_plan[p]);
            steady = (p == 2);
            for (i = 0; i < PHASE_WORDS; i++) begin
                roll = $urandom_range(99);
                if (roll < 30)
                    send_word(OP_LOAD, IDX_W'($urandom), load_amount());
                else if (roll < 85) begin
                    lim = (scan_plan[p] < HOLE_SLOTS) ? int'(scan_plan[p]) : HOLE_SLOTS;
                    j   = (lim > 0) ? $urandom_range(lim - 1) : 0;
                    amt = SIZE_W'($urandom_range(ledger.hole_sizes[j]));
                    send_word(OP_REQUEST, IDX_W'($urandom), amt);
                end
                else
                    send_word(1'($urandom), IDX_W'($urandom), SIZE_W'($urandom));
            end
        end
        steady = 0;

        // Drain, then let the clock run on so the block can show any stray word
        settle();
        repeat (20) @(negedge clk);

        $display("covered %0d loads and %0d requests (%0d refused, %0d of size zero)",
                 ledger.n_loads, ledger.n_requests, ledger.n_refused,
                 ledger.n_zero_requests);
        $display("over %0d register writes: all fit modes, scan counts 0 to 31; %0d errors",
                 ledger.n_writes, ledger.errors);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
